>>> src/keyboard_scan_code_decoder_fifo_defines.svh
// assertion macros shared by the keyboard decoder rtl
`ifndef KEYBOARD_SCAN_CODE_DECODER_FIFO_DEFINES_SVH
`define KEYBOARD_SCAN_CODE_DECODER_FIFO_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define KSCD_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define KSCD_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/kscd_pkg.sv
// package: command types, scan code constants and ascii lookup tables
`default_nettype none

package kscd_pkg;

    // scan codes with a fixed meaning
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
    localparam logic [7:0] SC_CTRL_MAKE    = 8'h1d;
    localparam logic [7:0] SC_CTRL_BREAK   = 8'h9d;
    localparam int         SC_BREAK_BIT    = 7;

    // character masks
    localparam logic [7:0] CTRL_CHAR_BITS = 8'h1f;
    localparam logic [7:0] FULL_MASK      = 8'hff;

    // command classes handed from front to back
    typedef enum logic [2:0] {
        OP_READ,
        OP_SHIFT_SET,
        OP_SHIFT_CLR,
        OP_CTRL_SET,
        OP_CTRL_CLR,
        OP_MAKE,
        OP_IGNORE
    } kscd_op_t;

    typedef struct packed {
        kscd_op_t   op;
        logic [6:0] code;
    } kscd_cmd_t;

    // queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } kscd_q_stat_t;

    // back end sequencer
    typedef enum logic {
        BK_RUN,
        BK_READ_DATA
    } kscd_back_state_t;

    // unshifted table, zero means no character
    function automatic logic [7:0] kscd_plain_char(input logic [6:0] code);
        logic [7:0] c;
        unique case (code)
            7'h01: c = 8'h1b;
            7'h02: c = 8'h31;
            7'h03: c = 8'h32;
            7'h04: c = 8'h33;
            7'h05: c = 8'h34;
            7'h06: c = 8'h35;
            7'h07: c = 8'h36;
            7'h08: c = 8'h37;
            7'h09: c = 8'h38;
            7'h0a: c = 8'h39;
            7'h0b: c = 8'h30;
            7'h0c: c = 8'h2d;
            7'h0d: c = 8'h3d;
            7'h0e: c = 8'h08;
            7'h0f: c = 8'h09;
            7'h10: c = 8'h71;
            7'h11: c = 8'h77;
            7'h12: c = 8'h65;
            7'h13: c = 8'h72;
            7'h14: c = 8'h74;
            7'h15: c = 8'h79;
            7'h16: c = 8'h75;
            7'h17: c = 8'h69;
            7'h18: c = 8'h6f;
            7'h19: c = 8'h70;
            7'h1a: c = 8'h5b;
            7'h1b: c = 8'h5d;
            7'h1c: c = 8'h0a;
            7'h1e: c = 8'h61;
            7'h1f: c = 8'h73;
            7'h20: c = 8'h64;
            7'h21: c = 8'h66;
            7'h22: c = 8'h67;
            7'h23: c = 8'h68;
            7'h24: c = 8'h6a;
            7'h25: c = 8'h6b;
            7'h26: c = 8'h6c;
            7'h27: c = 8'h3b;
            7'h28: c = 8'h27;
            7'h29: c = 8'h60;
            7'h2b: c = 8'h5c;
            7'h2c: c = 8'h7a;
            7'h2d: c = 8'h78;
            7'h2e: c = 8'h63;
            7'h2f: c = 8'h76;
            7'h30: c = 8'h62;
            7'h31: c = 8'h6e;
            7'h32: c = 8'h6d;
            7'h33: c = 8'h2c;
            7'h34: c = 8'h2e;
            7'h35: c = 8'h2f;
            7'h37: c = 8'h2a;
            7'h39: c = 8'h20;
            7'h47: c = 8'h37;
            7'h48: c = 8'h38;
            7'h49: c = 8'h39;
            7'h4a: c = 8'h2d;
            7'h4b: c = 8'h34;
            7'h4c: c = 8'h35;
            7'h4d: c = 8'h36;
            7'h4e: c = 8'h2b;
            7'h4f: c = 8'h31;
            7'h50: c = 8'h32;
            7'h51: c = 8'h33;
            7'h52: c = 8'h30;
            7'h53: c = 8'h2e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // shifted table, zero means no character
    function automatic logic [7:0] kscd_upper_char(input logic [6:0] code);
        logic [7:0] c;
        unique case (code)
            7'h01: c = 8'h1b;
            7'h02: c = 8'h21;
            7'h03: c = 8'h40;
            7'h04: c = 8'h23;
            7'h05: c = 8'h24;
            7'h06: c = 8'h25;
            7'h07: c = 8'h5e;
            7'h08: c = 8'h26;
            7'h09: c = 8'h2a;
            7'h0a: c = 8'h28;
            7'h0b: c = 8'h29;
            7'h0c: c = 8'h5f;
            7'h0d: c = 8'h2b;
            7'h0e: c = 8'h08;
            7'h0f: c = 8'h09;
            7'h10: c = 8'h51;
            7'h11: c = 8'h57;
            7'h12: c = 8'h45;
            7'h13: c = 8'h52;
            7'h14: c = 8'h54;
            7'h15: c = 8'h59;
            7'h16: c = 8'h55;
            7'h17: c = 8'h49;
            7'h18: c = 8'h4f;
            7'h19: c = 8'h50;
            7'h1a: c = 8'h7b;
            7'h1b: c = 8'h7d;
            7'h1c: c = 8'h0a;
            7'h1e: c = 8'h41;
            7'h1f: c = 8'h53;
            7'h20: c = 8'h44;
            7'h21: c = 8'h46;
            7'h22: c = 8'h47;
            7'h23: c = 8'h48;
            7'h24: c = 8'h4a;
            7'h25: c = 8'h4b;
            7'h26: c = 8'h4c;
            7'h27: c = 8'h3a;
            7'h28: c = 8'h22;
            7'h29: c = 8'h7e;
            7'h2b: c = 8'h7c;
            7'h2c: c = 8'h5a;
            7'h2d: c = 8'h58;
            7'h2e: c = 8'h43;
            7'h2f: c = 8'h56;
            7'h30: c = 8'h42;
            7'h31: c = 8'h4e;
            7'h32: c = 8'h4d;
            7'h33: c = 8'h3c;
            7'h34: c = 8'h3e;
            7'h35: c = 8'h3f;
            7'h37: c = 8'h2a;
            7'h39: c = 8'h20;
            7'h47: c = 8'h37;
            7'h48: c = 8'h38;
            7'h49: c = 8'h39;
            7'h4a: c = 8'h2d;
            7'h4b: c = 8'h34;
            7'h4c: c = 8'h35;
            7'h4d: c = 8'h36;
            7'h4e: c = 8'h2b;
            7'h4f: c = 8'h31;
            7'h50: c = 8'h32;
            7'h51: c = 8'h33;
            7'h52: c = 8'h30;
            7'h53: c = 8'h2e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/keyboard_scan_code_decoder_fifo.sv
// top level: keyboard scan code decoder with character ring buffer
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  mode, scan_byte
//   out      from block out_valid / out_stall char_valid, char_out, dropped, stored_count
//
// the back end retires one request per cycle while the queue is not empty and the result
// register is free; a read that finds characters also passes the BK_READ_DATA state,
// because the ring memory has a registered read port, and takes no new request meanwhile.
// in_stall rises only when the two-entry command queue is full.
// the result register holds while out_stall is high; the ring needs no clear after reset.
`default_nettype none

module keyboard_scan_code_decoder_fifo #(
    parameter int RING_DEPTH = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       mode,
    input  wire logic [7:0] scan_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            char_valid,
    output logic [7:0]      char_out,
    output logic            dropped,
    output logic [7:0]      stored_count
);
    import kscd_pkg::*;

    kscd_q_stat_t q_stat;
    kscd_cmd_t    push_cmd;
    kscd_cmd_t    pop_cmd;
    logic         push;
    logic         pop;

    // request classification
    kscd_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .scan_byte(scan_byte),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decoupling queue
    kscd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .pop_cmd (pop_cmd),
        .q_stat  (q_stat)
    );

    // execution and result
    kscd_back #(
        .RING_DEPTH(RING_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_cmd       (pop_cmd),
        .q_stat      (q_stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_valid  (char_valid),
        .char_out    (char_out),
        .dropped     (dropped),
        .stored_count(stored_count)
    );

endmodule

`default_nettype wire

>>> src/kscd_front.sv
// front end: accepts requests and classifies them into commands
`default_nettype none

module kscd_front (
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 mode,
    input  wire logic [7:0]           scan_byte,
    input  wire kscd_pkg::kscd_q_stat_t q_stat,
    output logic                      push,
    output kscd_pkg::kscd_cmd_t       push_cmd
);
    import kscd_pkg::*;

    // stall only while the queue has no room
    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    // classify the request
    always_comb
    begin
        push_cmd.code = scan_byte[6:0];
        priority if (mode)
            push_cmd.op = OP_READ;
        else if (scan_byte == SC_LSHIFT_MAKE || scan_byte == SC_RSHIFT_MAKE)
            push_cmd.op = OP_SHIFT_SET;
        else if (scan_byte == SC_LSHIFT_BREAK || scan_byte == SC_RSHIFT_BREAK)
            push_cmd.op = OP_SHIFT_CLR;
        else if (scan_byte == SC_CTRL_MAKE)
            push_cmd.op = OP_CTRL_SET;
        else if (scan_byte == SC_CTRL_BREAK)
            push_cmd.op = OP_CTRL_CLR;
        else if (!scan_byte[SC_BREAK_BIT])
            push_cmd.op = OP_MAKE;
        else
            push_cmd.op = OP_IGNORE;
    end

endmodule

`default_nettype wire

>>> src/kscd_queue.sv
// two-entry command queue between front and back
`default_nettype none
`include "keyboard_scan_code_decoder_fifo_defines.svh"

module kscd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire kscd_pkg::kscd_cmd_t push_cmd,
    input  wire logic                pop,
    output kscd_pkg::kscd_cmd_t      pop_cmd,
    output kscd_pkg::kscd_q_stat_t   q_stat
);
    import kscd_pkg::*;

    kscd_cmd_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    assign pop_cmd      = entry_reg[rd_ptr_reg];
    assign q_stat.empty = (cnt_reg == 2'd0);
    assign q_stat.full  = (cnt_reg == 2'd2);

    `KSCD_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !q_stat.full, "push into full queue")
    `KSCD_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, !q_stat.empty, "pop from empty queue")
    `KSCD_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= 2'd2, "queue count overflow")

endmodule

`default_nettype wire

>>> src/kscd_back.sv
// back end: modifier state, ascii lookup, character ring and result register
`default_nettype none
`include "keyboard_scan_code_decoder_fifo_defines.svh"

module kscd_back #(
    parameter int RING_DEPTH = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire kscd_pkg::kscd_cmd_t   q_cmd,
    input  wire kscd_pkg::kscd_q_stat_t q_stat,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       char_valid,
    output logic [7:0]                 char_out,
    output logic                       dropped,
    output logic [7:0]                 stored_count
);
    import kscd_pkg::*;

    localparam int CNT_W = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
    localparam int SAT_W = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(RING_DEPTH - 1);

    kscd_back_state_t state_reg, state_next;
    logic             shift_reg, shift_next;
    logic             ctrl_reg, ctrl_next;
    logic [CNT_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             out_valid_reg, out_valid_next;
    logic             char_valid_reg, char_valid_next;
    logic [7:0]       char_out_reg, char_out_next;
    logic             dropped_reg, dropped_next;
    logic [7:0]       stored_count_reg, stored_count_next;

    logic [7:0]       ring [RING_DEPTH];
    logic [7:0]       ring_q_reg;
    logic             ring_we, ring_re;
    logic [7:0]       ring_wdata;

    logic             out_free;
    logic             ring_full;
    logic [7:0]       lookup_char;

    // saturate the fill count to the 8-bit result field
    function automatic logic [7:0] sat_count(input logic [CNT_W-1:0] n);
        logic [SAT_W-1:0] n_ext;
        n_ext = SAT_W'(n);
        return (n_ext > SAT_W'(255)) ? 8'hff : n_ext[7:0];
    endfunction

    function automatic logic [CNT_W-1:0] slot_inc(input logic [CNT_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + CNT_W'(1);
    endfunction

    assign out_free    = !out_valid_reg || !out_stall;
    assign ring_full   = (cnt_reg == LAST_SLOT);
    assign lookup_char = shift_reg ? kscd_upper_char(q_cmd.code) : kscd_plain_char(q_cmd.code);

    // sequencer and datapath next state
    always_comb
    begin
        state_next        = state_reg;
        shift_next        = shift_reg;
        ctrl_next         = ctrl_reg;
        wr_ptr_next       = wr_ptr_reg;
        rd_ptr_next       = rd_ptr_reg;
        cnt_next          = cnt_reg;
        out_valid_next    = out_valid_reg && out_stall;
        char_valid_next   = char_valid_reg;
        char_out_next     = char_out_reg;
        dropped_next      = dropped_reg;
        stored_count_next = stored_count_reg;
        pop               = 1'b0;
        ring_we           = 1'b0;
        ring_re           = 1'b0;
        ring_wdata        = lookup_char & (ctrl_reg ? CTRL_CHAR_BITS : FULL_MASK);

        unique case (state_reg)
            BK_RUN:
            begin
                if (!q_stat.empty && out_free)
                begin
                    pop             = 1'b1;
                    out_valid_next  = 1'b1;
                    char_valid_next = 1'b0;
                    char_out_next   = 8'h00;
                    dropped_next    = 1'b0;
                    unique case (q_cmd.op)
                        OP_READ:
                        begin
                            if (cnt_reg != '0)
                            begin
                                // data comes out of the ring next cycle
                                ring_re        = 1'b1;
                                rd_ptr_next    = slot_inc(rd_ptr_reg);
                                cnt_next       = cnt_reg - CNT_W'(1);
                                out_valid_next = 1'b0;
                                state_next     = BK_READ_DATA;
                            end
                        end
                        OP_SHIFT_SET: shift_next = 1'b1;
                        OP_SHIFT_CLR: shift_next = 1'b0;
                        OP_CTRL_SET:  ctrl_next  = 1'b1;
                        OP_CTRL_CLR:  ctrl_next  = 1'b0;
                        OP_MAKE:
                        begin
                            if (lookup_char != 8'h00)
                            begin
                                if (ring_full)
                                    dropped_next = 1'b1;
                                else
                                begin
                                    ring_we     = 1'b1;
                                    wr_ptr_next = slot_inc(wr_ptr_reg);
                                    cnt_next    = cnt_reg + CNT_W'(1);
                                end
                            end
                        end
                        OP_IGNORE: ;
                        default: ;
                    endcase
                    stored_count_next = sat_count(cnt_next);
                end
            end
            BK_READ_DATA:
            begin
                // wait for the result register, ring data holds meanwhile
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    char_valid_next   = 1'b1;
                    char_out_next     = ring_q_reg;
                    dropped_next      = 1'b0;
                    stored_count_next = sat_count(cnt_reg);
                    state_next        = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            shift_reg     <= 1'b0;
            ctrl_reg      <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shift_reg     <= shift_next;
            ctrl_reg      <= ctrl_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        char_valid_reg   <= char_valid_next;
        char_out_reg     <= char_out_next;
        dropped_reg      <= dropped_next;
        stored_count_reg <= stored_count_next;
    end

    // character ring, registered read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring[wr_ptr_reg] <= ring_wdata;
        if (ring_re)
            ring_q_reg <= ring[rd_ptr_reg];
    end

    assign out_valid    = out_valid_reg;
    assign char_valid   = char_valid_reg;
    assign char_out     = char_out_reg;
    assign dropped      = dropped_reg;
    assign stored_count = stored_count_reg;

    `KSCD_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= LAST_SLOT, "ring count overflow")
    `KSCD_ASSERT_NOW(a_drop_no_char, clk, rst_n, out_valid_reg && dropped_reg, !char_valid_reg,
        "drop flagged on a read result")
    `KSCD_ASSERT_NEXT(a_read_wait, clk, rst_n, ring_re, state_reg == BK_READ_DATA && !out_valid_reg,
        "ring read not followed by data state")

endmodule

`default_nettype wire

>>> tb/sv/kscd_result_checker.sv
// checker for the keyboard decoder: predicts each response and compares it on the output channel
`default_nettype none

module kscd_result_checker #(
    parameter int RING_DEPTH = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic       mode,
    input  wire logic [7:0] scan_byte,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic       char_valid,
    input  wire logic [7:0] char_out,
    input  wire logic       dropped,
    input  wire logic [7:0] stored_count,
    output int              fail_count,
    output int              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import kscd_pkg::*;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       dropped;
        logic [7:0] stored_count;
    } key_response_t;

    // highest make code with a table entry
    localparam logic [7:0] LAST_MAPPED_CODE = 8'h53;
    localparam logic [7:0] COUNT_CEILING    = 8'hff;

    // ascii for make codes 0x00..0x53, zero where the key has no character
    localparam logic [7:0] PLAIN_ASCII [0:83] = '{
        8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
        8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2e
    };

    localparam logic [7:0] SHIFTED_ASCII [0:83] = '{
        8'h00, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
        8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0a, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
        8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2e
    };

    // shadow copy of the decoder state
    logic          shift_on = 1'b0;
    logic          ctrl_on  = 1'b0;
    logic [7:0]    char_store [RING_DEPTH];
    int            wr_slot = 0;
    int            rd_slot = 0;
    key_response_t response_q [$];
    int            errors = 0;

    assign fail_count = errors;
    assign pending    = response_q.size();

    function automatic int next_slot(input int s);
        return (s + 1 >= RING_DEPTH) ? 0 : s + 1;
    endfunction

    // characters in the ring, clipped to what the count port can show
    function automatic logic [7:0] chars_held();
        int n;
        n = (wr_slot >= rd_slot) ? wr_slot - rd_slot : wr_slot + RING_DEPTH - rd_slot;
        return (n > int'(COUNT_CEILING)) ? COUNT_CEILING : n[7:0];
    endfunction

    // apply one request to the shadow state and queue the response it must produce
    task automatic decode_request(input logic is_read, input logic [7:0] code);
        key_response_t rsp;
        logic [7:0]    ch;
        int            nxt;
        rsp = '0;
        if (is_read)
        begin
            // pop the oldest character unless the ring is empty
            if (rd_slot != wr_slot)
            begin
                rsp.char_valid = 1'b1;
                rsp.char_out   = char_store[rd_slot];
                rd_slot        = next_slot(rd_slot);
            end
        end
        else if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE)
        begin
            shift_on = 1'b1;
        end
        else if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK)
        begin
            shift_on = 1'b0;
        end
        else if (code == SC_CTRL_MAKE)
        begin
            ctrl_on = 1'b1;
        end
        else if (code == SC_CTRL_BREAK)
        begin
            ctrl_on = 1'b0;
        end
        else if (!code[SC_BREAK_BIT])
        begin
            // make code: look up, mask under control, store or drop when full
            ch = 8'h00;
            if (code <= LAST_MAPPED_CODE)
                ch = shift_on ? SHIFTED_ASCII[code] : PLAIN_ASCII[code];
            if (ch != 8'h00)
            begin
                nxt = next_slot(wr_slot);
                if (nxt != rd_slot)
                begin
                    char_store[wr_slot] = ch & (ctrl_on ? CTRL_CHAR_BITS : FULL_MASK);
                    wr_slot = nxt;
                end
                else
                begin
                    rsp.dropped = 1'b1;
                end
            end
        end
        rsp.stored_count = chars_held();
        response_q.push_back(rsp);
    endtask

    // compare one response from the block with the oldest prediction
    task automatic check_response();
        key_response_t exp_rsp;
        if (response_q.size() == 0)
        begin
            $error("response with no request outstanding");
            errors++;
        end
        else
        begin
            exp_rsp = response_q.pop_front();
            if (char_valid !== exp_rsp.char_valid)
            begin
                $error("char_valid: expected %0d, got %0d", exp_rsp.char_valid, char_valid);
                errors++;
            end
            if (char_out !== exp_rsp.char_out)
            begin
                $error("char_out: expected %02h, got %02h", exp_rsp.char_out, char_out);
                errors++;
            end
            if (dropped !== exp_rsp.dropped)
            begin
                $error("dropped: expected %0d, got %0d", exp_rsp.dropped, dropped);
                errors++;
            end
            if (stored_count !== exp_rsp.stored_count)
            begin
                $error("stored_count: expected %0d, got %0d",
                       exp_rsp.stored_count, stored_count);
                errors++;
            end
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_on = 1'b0;
            ctrl_on  = 1'b0;
            wr_slot  = 0;
            rd_slot  = 0;
            response_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                decode_request(mode, scan_byte);
            if (out_valid && !out_stall)
                check_response();
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/keyboard_scan_code_decoder_fifo_tb.sv
// testbench top for the keyboard decoder: clock, reset, request stimulus, stalls and verdict
`default_nettype none

module keyboard_scan_code_decoder_fifo_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kscd_pkg::*;

    localparam int   RING_DEPTH   = 256;
    localparam int   ITEM_TARGET  = 900;
    localparam int   IDLE_LIMIT   = 2000;
    localparam int   SETTLE_CYCLES = 10;
    localparam logic MODE_SCAN    = 1'b0;
    localparam logic MODE_READ    = 1'b1;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       mode      = MODE_SCAN;
    logic [7:0] scan_byte = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       char_valid;
    logic [7:0] char_out;
    logic       dropped;
    logic [7:0] stored_count;

    int fail_count;
    int pending;
    int sent        = 0;
    int idle_cycles = 0;
    int stall_hold  = 0;
    bit steady_in   = 1'b0;
    bit steady_out  = 1'b0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    keyboard_scan_code_decoder_fifo #(
        .RING_DEPTH(RING_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .scan_byte(scan_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .char_valid(char_valid),
        .char_out(char_out),
        .dropped(dropped),
        .stored_count(stored_count)
    );

    kscd_result_checker #(
        .RING_DEPTH(RING_DEPTH)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .scan_byte(scan_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .char_valid(char_valid),
        .char_out(char_out),
        .dropped(dropped),
        .stored_count(stored_count),
        .fail_count(fail_count),
        .pending(pending)
    );

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls: mostly short runs, a few long ones, none in steady stretches
    always @(negedge clk)
    begin
        if (stall_hold == 0)
        begin
            if (steady_out)
            begin
                out_stall  = 1'b0;
                stall_hold = $urandom_range(1, 10);
            end
            else
            begin
                case ($urandom % 20)
                    0, 1:
                    begin
                        out_stall  = 1'b1;
                        stall_hold = $urandom_range(10, 40);
                    end
                    2, 3, 4, 5, 6, 7, 8:
                    begin
                        out_stall  = 1'b1;
                        stall_hold = $urandom_range(1, 3);
                    end
                    default:
                    begin
                        out_stall  = 1'b0;
                        stall_hold = $urandom_range(1, 8);
                    end
                endcase
            end
        end
        else
        begin
            stall_hold--;
        end
    end

    // sender gap after a request: mostly none or short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom % 100;
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // scan byte: typing favors make codes, otherwise a mix of modifiers, releases and noise
    function automatic logic [7:0] pick_scan(input bit typing);
        int r;
        r = $urandom % 100;
        if (typing && r < 85)
            return 8'($urandom_range(8'h02, 8'h35));
        if (r < 8)
            return ($urandom % 2) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
        else if (r < 16)
            return ($urandom % 2) ? SC_LSHIFT_BREAK : SC_RSHIFT_BREAK;
        else if (r < 19)
            return SC_CTRL_MAKE;
        else if (r < 24)
            return SC_CTRL_BREAK;
        else if (r < 78)
            return 8'($urandom_range(8'h01, 8'h53));
        else if (r < 90)
            return 8'h80 | 8'($urandom_range(8'h01, 8'h53));
        return 8'($urandom_range(0, 255));
    endfunction

    // drive one request, hold it until accepted, then idle for a random gap
    task automatic send_request(input logic m, input logic [7:0] b);
        int gap;
        @(negedge clk);
        in_valid  = 1'b1;
        mode      = m;
        scan_byte = b;
        do @(posedge clk); while (in_stall);
        sent++;
        gap = steady_in ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid  = 1'b0;
            mode      = 1'($urandom);
            scan_byte = 8'($urandom);
        end
    endtask

    // stop sending until every predicted response has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int phase_no;
        int phase_len;
        int scan_pct;
        bit typing;
        phase_no = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty read, undefined codes, releases, shift and control, reads
        send_request(MODE_READ, 8'hff);
        send_request(MODE_SCAN, 8'h00);
        send_request(MODE_SCAN, 8'h7f);
        send_request(MODE_SCAN, 8'h1e);
        send_request(MODE_SCAN, 8'h9e);
        send_request(MODE_SCAN, 8'h80);
        send_request(MODE_SCAN, SC_LSHIFT_MAKE);
        send_request(MODE_SCAN, 8'h1e);
        send_request(MODE_SCAN, 8'h02);
        send_request(MODE_SCAN, SC_LSHIFT_BREAK);
        send_request(MODE_SCAN, SC_RSHIFT_MAKE);
        send_request(MODE_SCAN, 8'h29);
        send_request(MODE_SCAN, SC_RSHIFT_BREAK);
        send_request(MODE_SCAN, SC_CTRL_MAKE);
        send_request(MODE_SCAN, 8'h2e);
        send_request(MODE_SCAN, SC_CTRL_BREAK);
        send_request(MODE_SCAN, 8'h53);
        send_request(MODE_SCAN, 8'h54);
        send_request(MODE_SCAN, 8'hff);
        send_request(MODE_READ, 8'h00);
        send_request(MODE_READ, 8'haa);
        send_request(MODE_READ, 8'h55);
        send_request(MODE_READ, 8'h1d);
        send_request(MODE_READ, 8'h2a);
        send_request(MODE_READ, 8'hff);
        send_request(MODE_READ, 8'h80);
        wait_drained();

        // random phases: a long typing burst to overflow the ring, a read burst to
        // empty it, then mixed phases
        while (sent < ITEM_TARGET)
        begin
            if (phase_no == 0)
            begin
                scan_pct  = 97;
                phase_len = 400;
                typing    = 1'b1;
            end
            else if (phase_no == 1)
            begin
                scan_pct  = 8;
                phase_len = 300;
                typing    = 1'b0;
            end
            else
            begin
                case ($urandom % 3)
                    0:       scan_pct = 85;
                    1:       scan_pct = 15;
                    default: scan_pct = 50;
                endcase
                phase_len = $urandom_range(20, 100);
                typing    = 1'($urandom % 2);
            end
            steady_in  = ($urandom % 4 == 0);
            steady_out = ($urandom % 4 == 0);
            repeat (phase_len)
            begin
                if ($urandom % 100 < scan_pct)
                    send_request(MODE_SCAN, pick_scan(typing));
                else
                    send_request(MODE_READ, 8'($urandom_range(0, 255)));
            end
            if (phase_no < 2 || $urandom % 3 == 0)
                wait_drained();
            phase_no++;
        end

        // let everything retire, then a short settle
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
